FILE: rtl/bfa_pkg.sv
// Shared types and constants of the bitmap first-fit allocator.
// Depends on nothing; every other file in rtl takes its names by scope.
package bfa_pkg;

   localparam int POOL_BYTES = 1024;
   localparam int WORD_BITS  = 8;
   localparam int NUM_WORDS  = POOL_BYTES / WORD_BITS;
   localparam int WIDX_W     = $clog2(NUM_WORDS);
   localparam int BIT_W      = $clog2(WORD_BITS);

   localparam int CMD_W    = 2;
   localparam int OFF_W    = 10;
   localparam int SIZE_W   = 11;
   localparam int STATUS_W = 2;

   // positions hold offset + size sums as well as pool addresses and counts
   localparam int POS_W = (SIZE_W + 1 > $clog2(POOL_BYTES) + 2) ?
                          SIZE_W + 1 : $clog2(POOL_BYTES) + 2;
   localparam int PTR_W = POS_W - BIT_W;
   localparam int NFREE_W = $clog2(WORD_BITS + 1);

   localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESIZE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_COUNT  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_RUN   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BEYOND   = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [OFF_W-1:0]  block_offset;
      logic [SIZE_W-1:0] request_size;
      logic [SIZE_W-1:0] old_size;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OFF_W-1:0]    result_offset;
      logic                relocated;
      logic [SIZE_W-1:0]   free_bytes;
   } rsp_type;

   typedef struct packed {
      logic                 rd_en;
      logic [WIDX_W-1:0]    rd_addr;
      logic                 wr_en;
      logic [WIDX_W-1:0]    wr_addr;
      logic [WORD_BITS-1:0] wr_data;
   } map_cmd_type;

   // byte range [lo, hi) of a pass, the value it writes and the run length sought
   typedef struct packed {
      logic [POS_W-1:0] lo;
      logic [POS_W-1:0] hi;
      logic             val;
      logic [POS_W-1:0] len;
   } pass_ctl_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] wr_word;
      logic                 hit;
      logic [POS_W-1:0]     run;
      logic                 found;
      logic [POS_W-1:0]     fpos;
      logic [NFREE_W-1:0]   nfree;
   } digit_res_type;

endpackage

FILE: rtl/bfa_map.sv
// Usage map storage: one word of map bits per address, registered read.
// Per-word valid flags make unwritten words read as free after reset. Uses bfa_pkg.
module bfa_map (
   input  logic                           clock,
   input  logic                           reset,
   input  bfa_pkg::map_cmd_type           cmd,
   output logic [bfa_pkg::WORD_BITS-1:0]  rd_data
);

   logic [bfa_pkg::WORD_BITS-1:0] map_mem [bfa_pkg::NUM_WORDS];
   logic [bfa_pkg::NUM_WORDS-1:0] valid_ff;
   logic [bfa_pkg::NUM_WORDS-1:0] valid_in;
   logic [bfa_pkg::WORD_BITS-1:0] q_ff;
   logic                          qv_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         map_mem[cmd.wr_addr] <= cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         q_ff  <= map_mem[cmd.rd_addr];
         qv_ff <= valid_ff[cmd.rd_addr];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.wr_en) begin
         valid_in[cmd.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_data = qv_ff ? q_ff : '0;

endmodule

FILE: rtl/bfa_digit.sv
// Per-word logic of a map sweep: range masking, used-bit check, free-run
// tracking across words and free-bit count. Uses bfa_pkg.
module bfa_digit (
   input  logic [bfa_pkg::WORD_BITS-1:0] data,
   input  logic [bfa_pkg::POS_W-1:0]     base,
   input  bfa_pkg::pass_ctl_type         ctl,
   input  logic [bfa_pkg::POS_W-1:0]     run_in,
   output bfa_pkg::digit_res_type        res
);

   logic [bfa_pkg::WORD_BITS-1:0] inr;
   logic [bfa_pkg::POS_W-1:0]     pos;
   logic [bfa_pkg::POS_W-1:0]     r;
   logic                          fnd;
   logic [bfa_pkg::POS_W-1:0]     fp;

   always_comb begin
      for (int i = 0; i < bfa_pkg::WORD_BITS; i++) begin
         pos    = base + bfa_pkg::POS_W'(i);
         inr[i] = (pos >= ctl.lo) && (pos < ctl.hi);
      end
   end

   // run of free bytes, carried in from the previous word
   always_comb begin
      r   = run_in;
      fnd = 1'b0;
      fp  = base;
      for (int i = 0; i < bfa_pkg::WORD_BITS; i++) begin
         if (data[i]) begin
            r = '0;
         end else begin
            r = r + 1'b1;
         end
         if (!fnd && r == ctl.len) begin
            fnd = 1'b1;
            fp  = base + bfa_pkg::POS_W'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < bfa_pkg::WORD_BITS; i++) begin
         res.wr_word[i] = inr[i] ? ctl.val : data[i];
      end
      res.hit   = |(inr & data);
      res.run   = r;
      res.found = fnd;
      res.fpos  = fp;
      res.nfree = bfa_pkg::NFREE_W'($countones(~data));
   end

endmodule

FILE: rtl/bitmap_first_fit_allocator.sv
// Bitmap first-fit allocator over a byte pool; one usage bit per byte.
// Takes one command item on req_valid/req_stall, returns one result item on
// rsp_valid/rsp_stall. Depends on bfa_pkg, bfa_map and bfa_digit.
//
// Usage: the block takes one command at a time. req_stall is high from the
// cycle after an item is accepted until its result has been taken. Each
// command sweeps the map one 8-bit word per cycle through a single read and
// a single write port of the map memory, so its cost is set by the number
// of words it touches:
//   count: a scan over all 128 words
//   allocate: a scan over up to 128 words (stops at first fit), a mark pass
//   free, shrink: one word per 8 bytes of range; grow: check + mark passes
//   resize that moves: check (if in pool) + scan + mark + clear passes
// Each pass adds pipeline fill and turnaround; each command adds capture and
// decode.
// Reset marks every byte free at once (per-word valid flags), no sweep.
// The result is held in an output register; while rsp_stall is high it
// stays put and no new command is taken.
module bitmap_first_fit_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bfa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bfa_pkg::rsp_type rsp_data
);

   localparam int POS_W = bfa_pkg::POS_W;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECODE = 2'd1;
   localparam logic [1:0] S_RUN    = 2'd2;
   localparam logic [1:0] S_RESP   = 2'd3;

   localparam logic [3:0] SP_ALLOC_SCAN  = 4'd0;
   localparam logic [3:0] SP_ALLOC_MARK  = 4'd1;
   localparam logic [3:0] SP_FREE_CLR    = 4'd2;
   localparam logic [3:0] SP_SHRINK_CLR  = 4'd3;
   localparam logic [3:0] SP_GROW_CHK    = 4'd4;
   localparam logic [3:0] SP_GROW_MARK   = 4'd5;
   localparam logic [3:0] SP_MOVE_SCAN   = 4'd6;
   localparam logic [3:0] SP_MOVE_MARK   = 4'd7;
   localparam logic [3:0] SP_MOVE_CLR    = 4'd8;
   localparam logic [3:0] SP_COUNT       = 4'd9;

   localparam logic [1:0] K_WRITE = 2'd0;
   localparam logic [1:0] K_CHECK = 2'd1;
   localparam logic [1:0] K_SCAN  = 2'd2;
   localparam logic [1:0] K_COUNT = 2'd3;

   function automatic logic [1:0] step_kind(input logic [3:0] step);
      logic [1:0] k;
      case (step)
         SP_ALLOC_SCAN, SP_MOVE_SCAN: k = K_SCAN;
         SP_GROW_CHK:                 k = K_CHECK;
         SP_COUNT:                    k = K_COUNT;
         default:                     k = K_WRITE;
      endcase
      return k;
   endfunction

   logic [1:0]                      state_ff, state_in;
   bfa_pkg::req_type                req_ff, req_in;
   logic [3:0]                      step_ff, step_in;
   logic [POS_W-1:0]                lo_ff, lo_in;
   logic [POS_W-1:0]                hi_ff, hi_in;
   logic [bfa_pkg::PTR_W-1:0]       ptr_ff, ptr_in;
   logic                            pend_ff, pend_in;
   logic [bfa_pkg::WIDX_W-1:0]      pend_ptr_ff, pend_ptr_in;
   logic                            stop_ff, stop_in;
   logic [POS_W-1:0]                run_ff, run_in;
   logic                            found_ff, found_in;
   logic [POS_W-1:0]                fpos_ff, fpos_in;
   logic                            hit_ff, hit_in;
   logic [POS_W-1:0]                cnt_ff, cnt_in;
   logic [bfa_pkg::OFF_W-1:0]       base_ff, base_in;
   logic [bfa_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic [bfa_pkg::OFF_W-1:0]       roff_ff, roff_in;
   logic                            reloc_ff, reloc_in;
   logic [bfa_pkg::SIZE_W-1:0]      free_ff, free_in;

   bfa_pkg::map_cmd_type            map_cmd;
   logic [bfa_pkg::WORD_BITS-1:0]   map_q;
   bfa_pkg::pass_ctl_type           ctl;
   bfa_pkg::digit_res_type          res;

   logic [POS_W-1:0] off_p, req_p, old_p, pool_p;
   logic [POS_W-1:0] sum_or, sum_oo;
   logic [POS_W-1:0] word_pos;
   logic [1:0]       kind;
   logic             more, issue, proc, done;
   logic             launch;
   logic [3:0]       nstep;
   logic [POS_W-1:0] nlo, nhi;

   assign off_p  = POS_W'(req_ff.block_offset);
   assign req_p  = POS_W'(req_ff.request_size);
   assign old_p  = POS_W'(req_ff.old_size);
   assign pool_p = POS_W'(bfa_pkg::POOL_BYTES);
   assign sum_or = off_p + req_p;
   assign sum_oo = off_p + old_p;

   assign kind     = step_kind(step_ff);
   assign word_pos = {ptr_ff, {bfa_pkg::BIT_W{1'b0}}};
   assign more     = !stop_ff && (word_pos < hi_ff) &&
                     (ptr_ff < bfa_pkg::PTR_W'(bfa_pkg::NUM_WORDS));
   assign issue    = (state_ff == S_RUN) && more;
   assign proc     = (state_ff == S_RUN) && pend_ff && !stop_ff;
   assign done     = (state_ff == S_RUN) && !pend_ff && !more;

   assign ctl.lo  = lo_ff;
   assign ctl.hi  = hi_ff;
   assign ctl.val = (step_ff == SP_ALLOC_MARK) || (step_ff == SP_GROW_MARK) ||
                    (step_ff == SP_MOVE_MARK);
   assign ctl.len = req_p;

   bfa_digit u_digit (
      .data   (map_q),
      .base   (POS_W'({pend_ptr_ff, {bfa_pkg::BIT_W{1'b0}}})),
      .ctl    (ctl),
      .run_in (run_ff),
      .res    (res)
   );

   always_comb begin
      map_cmd.rd_en   = issue;
      map_cmd.rd_addr = ptr_ff[bfa_pkg::WIDX_W-1:0];
      map_cmd.wr_en   = proc && (kind == K_WRITE);
      map_cmd.wr_addr = pend_ptr_ff;
      map_cmd.wr_data = res.wr_word;
   end

   bfa_map u_map (
      .clock   (clock),
      .reset   (reset),
      .cmd     (map_cmd),
      .rd_data (map_q)
   );

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      step_in     = step_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      ptr_in      = ptr_ff;
      pend_in     = issue;
      pend_ptr_in = issue ? ptr_ff[bfa_pkg::WIDX_W-1:0] : pend_ptr_ff;
      stop_in     = stop_ff;
      run_in      = run_ff;
      found_in    = found_ff;
      fpos_in     = fpos_ff;
      hit_in      = hit_ff;
      cnt_in      = cnt_ff;
      base_in     = base_ff;
      status_in   = status_ff;
      roff_in     = roff_ff;
      reloc_in    = reloc_ff;
      free_in     = free_ff;
      launch      = 1'b0;
      nstep       = step_ff;
      nlo         = '0;
      nhi         = pool_p;

      if (issue) begin
         ptr_in = ptr_ff + 1'b1;
      end

      if (proc) begin
         case (kind)
            K_CHECK: begin
               if (res.hit) begin
                  hit_in  = 1'b1;
                  stop_in = 1'b1;
               end
            end
            K_SCAN: begin
               run_in = res.run;
               if (res.found) begin
                  found_in = 1'b1;
                  fpos_in  = res.fpos;
                  stop_in  = 1'b1;
               end
            end
            K_COUNT: begin
               cnt_in = cnt_ff + POS_W'(res.nfree);
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in = bfa_pkg::ST_OK;
            roff_in   = '0;
            reloc_in  = 1'b0;
            free_in   = '0;
            case (req_ff.command)
               bfa_pkg::CMD_ALLOC: begin
                  if (req_p == '0 || req_p > pool_p) begin
                     status_in = bfa_pkg::ST_BAD_SIZE;
                     state_in  = S_RESP;
                  end else begin
                     launch = 1'b1;
                     nstep  = SP_ALLOC_SCAN;
                  end
               end
               bfa_pkg::CMD_FREE: begin
                  if (req_p == '0) begin
                     state_in = S_RESP;
                  end else begin
                     if (sum_or > pool_p) begin
                        status_in = bfa_pkg::ST_BEYOND;
                     end
                     launch = 1'b1;
                     nstep  = SP_FREE_CLR;
                     nlo    = off_p;
                     nhi    = sum_or;
                  end
               end
               bfa_pkg::CMD_RESIZE: begin
                  if (req_p == '0 || req_p > pool_p) begin
                     status_in = bfa_pkg::ST_BAD_SIZE;
                     state_in  = S_RESP;
                  end else if (old_p > req_p) begin
                     launch = 1'b1;
                     nstep  = SP_SHRINK_CLR;
                     nlo    = sum_or;
                     nhi    = sum_oo;
                  end else if (old_p == req_p) begin
                     roff_in  = req_ff.block_offset;
                     state_in = S_RESP;
                  end else if (sum_or > pool_p) begin
                     // growth would run off the end of the pool
                     launch = 1'b1;
                     nstep  = SP_MOVE_SCAN;
                  end else begin
                     launch = 1'b1;
                     nstep  = SP_GROW_CHK;
                     nlo    = sum_oo;
                     nhi    = sum_or;
                  end
               end
               default: begin
                  launch = 1'b1;
                  nstep  = SP_COUNT;
               end
            endcase
         end
         S_RUN: begin
            if (done) begin
               case (step_ff)
                  SP_ALLOC_SCAN, SP_MOVE_SCAN: begin
                     if (found_ff) begin
                        launch  = 1'b1;
                        nstep   = (step_ff == SP_ALLOC_SCAN) ? SP_ALLOC_MARK :
                                                               SP_MOVE_MARK;
                        nhi     = fpos_ff + 1'b1;
                        nlo     = fpos_ff + 1'b1 - req_p;
                        base_in = nlo[bfa_pkg::OFF_W-1:0];
                     end else begin
                        status_in = bfa_pkg::ST_NO_RUN;
                        state_in  = S_RESP;
                     end
                  end
                  SP_ALLOC_MARK: begin
                     roff_in  = base_ff;
                     state_in = S_RESP;
                  end
                  SP_GROW_CHK: begin
                     launch = 1'b1;
                     if (hit_ff) begin
                        nstep = SP_MOVE_SCAN;
                     end else begin
                        nstep = SP_GROW_MARK;
                        nlo   = sum_oo;
                        nhi   = sum_or;
                     end
                  end
                  SP_GROW_MARK, SP_SHRINK_CLR: begin
                     roff_in  = req_ff.block_offset;
                     state_in = S_RESP;
                  end
                  SP_MOVE_MARK: begin
                     launch = 1'b1;
                     nstep  = SP_MOVE_CLR;
                     nlo    = off_p;
                     nhi    = sum_oo;
                  end
                  SP_MOVE_CLR: begin
                     roff_in  = base_ff;
                     reloc_in = 1'b1;
                     state_in = S_RESP;
                  end
                  SP_COUNT: begin
                     free_in  = cnt_ff[bfa_pkg::SIZE_W-1:0];
                     state_in = S_RESP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (launch) begin
         state_in = S_RUN;
         step_in  = nstep;
         lo_in    = nlo;
         hi_in    = nhi;
         ptr_in   = nlo[POS_W-1:bfa_pkg::BIT_W];
         stop_in  = 1'b0;
         run_in   = '0;
         found_in = 1'b0;
         hit_in   = 1'b0;
         cnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
         stop_ff  <= 1'b0;
         found_ff <= 1'b0;
         hit_ff   <= 1'b0;
         step_ff  <= SP_ALLOC_SCAN;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         stop_ff  <= stop_in;
         found_ff <= found_in;
         hit_ff   <= hit_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      ptr_ff      <= ptr_in;
      pend_ptr_ff <= pend_ptr_in;
      run_ff      <= run_in;
      fpos_ff     <= fpos_in;
      cnt_ff      <= cnt_in;
      base_ff     <= base_in;
      status_ff   <= status_in;
      roff_ff     <= roff_in;
      reloc_ff    <= reloc_in;
      free_ff     <= free_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      rsp_data.status        = status_ff;
      rsp_data.result_offset = roff_ff;
      rsp_data.relocated     = reloc_ff;
      rsp_data.free_bytes    = free_ff;
   end

   a_write_in_pass: assert property (@(posedge clock) disable iff (reset)
      map_cmd.wr_en |-> state_ff == S_RUN)
      else $error("map written outside a pass");

   a_no_read_after_stop: assert property (@(posedge clock) disable iff (reset)
      stop_ff |-> !map_cmd.rd_en)
      else $error("map read issued after the pass stopped");

   a_reloc_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.relocated |-> rsp_data.status == bfa_pkg::ST_OK)
      else $error("relocated result with error status");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_DECODE)
      else $error("accepted item not decoded");

endmodule
